// ----- rtl/prras_pkg.sv -----
package prras_pkg;

    localparam int DEFAULT_TASK_SLOTS      = 64;
    localparam int DEFAULT_PRIORITY_LEVELS = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0]  CSC_RESET   = 8'd1;
    localparam logic [15:0] AGING_RESET = 16'd10;
    localparam logic [7:0]  QBASE_RESET = 8'd6;

    typedef enum logic [1:0] {
        OP_ARRIVE    = 2'd0,
        OP_DISPATCH  = 2'd1,
        OP_SLICE_END = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_ENQUEUED   = 3'd0,
        ST_DISPATCHED = 3'd1,
        ST_NONE_READY = 3'd2,
        ST_FINISHED   = 3'd3,
        ST_REQUEUED   = 3'd4,
        ST_REJECTED   = 3'd5
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CONTEXT_SWITCH_COST = 2'd0,
        CFG_AGING_THRESHOLD     = 2'd1,
        CFG_QUANTUM_BASE        = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  task_id;
        logic [3:0]  base_priority;
        logic [15:0] burst;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  out_task;
        logic [3:0]  priority_level;
        logic [8:0]  run_length;
        logic [31:0] event_time;
        logic [31:0] waited;
    } rsp_t;

endpackage

// ----- rtl/priority_round_robin_aging_scheduler.sv -----
// Multilevel ready-queue scheduler with round-robin slices and priority aging.
// Request channel (req_valid, req_stall, req) carries one event: an arrival,
// a dispatch request or the end of the running slice. Response channel
// (rsp_valid, rsp_stall, rsp) returns exactly one response per request, in
// order. Configuration writes use cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Writes are to be made by the user only
// while no request is in flight; the block itself does not enforce it.
// A taken request is registered in the execute stage and its response in
// the output register.
// Throughput is one request per cycle while the receiver takes responses.
// The task tables are read in the cycle before the execute stage, at the slot
// chosen from the queue state that the request in execute leaves, with its
// table writes forwarded into that read.
// When the receiver stalls, the response is held in the output register and
// one further request may wait in the execute stage; req_stall then rises.
// Reset empties every queue, clears all live slots and the running slice,
// and loads the configuration defaults (switch cost 1, aging threshold 10,
// quantum base 6). No clearing pass is needed.
module priority_round_robin_aging_scheduler
    import prras_pkg::*;
#(
    parameter int TASK_SLOTS      = DEFAULT_TASK_SLOTS,
    parameter int PRIORITY_LEVELS = DEFAULT_PRIORITY_LEVELS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_t                   req,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rsp_t                   rsp,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int TW = $clog2(TASK_SLOTS);
    localparam int LW = $clog2(PRIORITY_LEVELS);
    localparam logic [LW-1:0] TOP = LW'(PRIORITY_LEVELS - 1);

    function automatic logic [LW-1:0] top_level(input logic [PRIORITY_LEVELS-1:0] mask);
        logic [LW-1:0] r;
        r = '0;
        for (int i = 0; i < PRIORITY_LEVELS; i++)
        begin
            if (mask[i])
            begin
                r = LW'(i);
            end
        end
        return r;
    endfunction

    // configuration
    logic [7:0]  csc_reg;
    logic [15:0] aging_reg;
    logic [7:0]  qbase_reg;

    // queue and run state
    logic [TW-1:0]              head_reg [PRIORITY_LEVELS];
    logic [TW-1:0]              head_next [PRIORITY_LEVELS];
    logic [TW-1:0]              tail_reg [PRIORITY_LEVELS];
    logic [TW-1:0]              tail_next [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [TASK_SLOTS-1:0]      live_reg, live_next;
    logic                       running_valid_reg, running_valid_next;
    logic [TW-1:0]              running_task_reg, running_task_next;
    logic [8:0]                 running_len_reg, running_len_next;
    logic [31:0]                running_end_reg, running_end_next;

    // task tables
    logic [LW-1:0] task_prio_reg [TASK_SLOTS];
    logic [15:0]   task_rem_reg  [TASK_SLOTS];
    logic [31:0]   task_time_reg [TASK_SLOTS];
    logic [TW-1:0] queue_link_reg [TASK_SLOTS];

    logic [LW-1:0] prio_rd_reg;
    logic [15:0]   rem_rd_reg;
    logic [31:0]   time_rd_reg;
    logic [TW-1:0] link_rd_reg;

    logic          prio_we, rem_we, time_we, link_we;
    logic [TW-1:0] prio_wa, rem_wa, time_wa, link_wa;
    logic [LW-1:0] prio_wd;
    logic [15:0]   rem_wd;
    logic [31:0]   time_wd;
    logic [TW-1:0] link_wd;

    // pipeline
    logic b_valid_reg;
    req_t b_req_reg;
    logic rsp_valid_reg;
    rsp_t rsp_reg, rsp_next;
    logic fire, acc;

    logic [LW-1:0] lvl, next_lvl, bp, new_prio;
    logic [TW-1:0] tidx, head_task, tail_task, rd_task;
    logic          in_range;
    logic [8:0]    quantum, run_len;
    logic [31:0]   run_start, wait_pre;
    logic [15:0]   new_rem;
    logic          push_en;
    logic [TW-1:0] push_task;
    logic [LW-1:0] push_lvl;
    logic [31:0]   push_time;

    assign fire      = b_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = b_valid_reg && !fire;
    assign acc       = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    assign lvl        = top_level(nonempty_reg);
    assign head_task  = head_reg[lvl];
    assign tail_task  = tail_reg[lvl];
    assign tidx       = TW'(b_req_reg.task_id);
    assign in_range   = 32'(b_req_reg.task_id) < 32'(TASK_SLOTS);
    assign bp         = (32'(b_req_reg.base_priority) > 32'(PRIORITY_LEVELS - 1))
                        ? TOP : LW'(b_req_reg.base_priority);
    assign quantum    = 9'(qbase_reg) + 9'(lvl >> 1);
    assign run_len    = (rem_rd_reg < 16'(quantum)) ? 9'(rem_rd_reg) : quantum;
    assign run_start  = b_req_reg.now + 32'(csc_reg);
    assign wait_pre   = b_req_reg.now - time_rd_reg;
    assign new_rem    = (rem_rd_reg > 16'(running_len_reg))
                        ? rem_rd_reg - 16'(running_len_reg) : '0;
    assign new_prio   = (prio_rd_reg != '0) ? prio_rd_reg - LW'(1) : '0;

    // execute stage
    always_comb
    begin
        head_next          = head_reg;
        tail_next          = tail_reg;
        nonempty_next      = nonempty_reg;
        live_next          = live_reg;
        running_valid_next = running_valid_reg;
        running_task_next  = running_task_reg;
        running_len_next   = running_len_reg;
        running_end_next   = running_end_reg;
        prio_we = 1'b0;
        prio_wa = head_task;
        prio_wd = prio_rd_reg;
        rem_we  = 1'b0;
        rem_wa  = tidx;
        rem_wd  = b_req_reg.burst;
        time_we = 1'b0;
        time_wa = tidx;
        time_wd = b_req_reg.now;
        link_we = 1'b0;
        link_wa = tail_task;
        link_wd = tidx;
        push_en   = 1'b0;
        push_task = tidx;
        push_lvl  = bp;
        push_time = b_req_reg.now;
        rsp_next            = '0;
        rsp_next.status     = ST_REJECTED;
        rsp_next.event_time = b_req_reg.now;
        if (fire)
        begin
            unique case (b_req_reg.op)
                OP_ARRIVE:
                begin
                    rsp_next.out_task = b_req_reg.task_id;
                    if (!in_range || live_reg[tidx])
                    begin
                        rsp_next.status = ST_REJECTED;
                    end
                    else
                    begin
                        live_next[tidx] = 1'b1;
                        prio_we = 1'b1;
                        prio_wa = tidx;
                        prio_wd = bp;
                        rem_we  = 1'b1;
                        rem_wa  = tidx;
                        rem_wd  = b_req_reg.burst;
                        push_en   = 1'b1;
                        push_task = tidx;
                        push_lvl  = bp;
                        push_time = b_req_reg.now;
                        rsp_next.status         = ST_ENQUEUED;
                        rsp_next.priority_level = 4'(bp);
                    end
                end
                OP_DISPATCH:
                begin
                    priority if (running_valid_reg)
                    begin
                        rsp_next.status   = ST_REJECTED;
                        rsp_next.out_task = 6'(running_task_reg);
                    end
                    else if (nonempty_reg == '0)
                    begin
                        rsp_next.status = ST_NONE_READY;
                    end
                    else
                    begin
                        if (tail_task == head_task)
                        begin
                            nonempty_next[lvl] = 1'b0;
                        end
                        else
                        begin
                            head_next[lvl] = link_rd_reg;
                        end
                        if (wait_pre > 32'(aging_reg) && prio_rd_reg < TOP)
                        begin
                            prio_we = 1'b1;
                            prio_wa = head_task;
                            prio_wd = prio_rd_reg + LW'(1);
                        end
                        running_valid_next = 1'b1;
                        running_task_next  = head_task;
                        running_len_next   = run_len;
                        running_end_next   = run_start + 32'(run_len);
                        rsp_next.status         = ST_DISPATCHED;
                        rsp_next.out_task       = 6'(head_task);
                        rsp_next.priority_level = 4'(lvl);
                        rsp_next.run_length     = run_len;
                        rsp_next.event_time     = run_start;
                        rsp_next.waited         = run_start - time_rd_reg;
                    end
                end
                OP_SLICE_END:
                begin
                    if (!running_valid_reg)
                    begin
                        rsp_next.status = ST_REJECTED;
                    end
                    else
                    begin
                        running_valid_next = 1'b0;
                        rem_we = 1'b1;
                        rem_wa = running_task_reg;
                        rem_wd = new_rem;
                        rsp_next.out_task   = 6'(running_task_reg);
                        rsp_next.event_time = running_end_reg;
                        if (new_rem == '0)
                        begin
                            live_next[running_task_reg] = 1'b0;
                            rsp_next.status         = ST_FINISHED;
                            rsp_next.priority_level = 4'(prio_rd_reg);
                        end
                        else
                        begin
                            prio_we = 1'b1;
                            prio_wa = running_task_reg;
                            prio_wd = new_prio;
                            push_en   = 1'b1;
                            push_task = running_task_reg;
                            push_lvl  = new_prio;
                            push_time = running_end_reg;
                            rsp_next.status         = ST_REQUEUED;
                            rsp_next.priority_level = 4'(new_prio);
                        end
                    end
                end
                default:
                begin
                    rsp_next.status = ST_REJECTED;
                end
            endcase
            if (push_en)
            begin
                time_we = 1'b1;
                time_wa = push_task;
                time_wd = push_time;
                if (nonempty_reg[push_lvl])
                begin
                    link_we = 1'b1;
                    link_wa = tail_reg[push_lvl];
                    link_wd = push_task;
                end
                else
                begin
                    head_next[push_lvl] = push_task;
                end
                tail_next[push_lvl]     = push_task;
                nonempty_next[push_lvl] = 1'b1;
            end
        end
    end

    // slot the incoming request will need, seen from the state left behind
    assign next_lvl = top_level(nonempty_next);
    assign rd_task  = (req.op == OP_DISPATCH) ? head_next[next_lvl] : running_task_next;

    always_ff @(posedge clk)
    begin
        if (prio_we)
        begin
            task_prio_reg[prio_wa] <= prio_wd;
        end
        if (acc)
        begin
            prio_rd_reg <= (prio_we && prio_wa == rd_task) ? prio_wd : task_prio_reg[rd_task];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            task_rem_reg[rem_wa] <= rem_wd;
        end
        if (acc)
        begin
            rem_rd_reg <= (rem_we && rem_wa == rd_task) ? rem_wd : task_rem_reg[rd_task];
        end
    end

    always_ff @(posedge clk)
    begin
        if (time_we)
        begin
            task_time_reg[time_wa] <= time_wd;
        end
        if (acc)
        begin
            time_rd_reg <= (time_we && time_wa == rd_task) ? time_wd : task_time_reg[rd_task];
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            queue_link_reg[link_wa] <= link_wd;
        end
        if (acc)
        begin
            link_rd_reg <= (link_we && link_wa == rd_task) ? link_wd : queue_link_reg[rd_task];
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
        if (acc)
        begin
            b_req_reg <= req;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg       <= 1'b0;
            rsp_valid_reg     <= 1'b0;
            nonempty_reg      <= '0;
            live_reg          <= '0;
            running_valid_reg <= 1'b0;
            running_task_reg  <= '0;
            running_len_reg   <= '0;
            running_end_reg   <= '0;
        end
        else
        begin
            if (acc)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                b_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            nonempty_reg      <= nonempty_next;
            live_reg          <= live_next;
            running_valid_reg <= running_valid_next;
            running_task_reg  <= running_task_next;
            running_len_reg   <= running_len_next;
            running_end_reg   <= running_end_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csc_reg   <= CSC_RESET;
            aging_reg <= AGING_RESET;
            qbase_reg <= QBASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CONTEXT_SWITCH_COST: csc_reg   <= cfg_data[7:0];
                CFG_AGING_THRESHOLD:     aging_reg <= cfg_data;
                CFG_QUANTUM_BASE:        qbase_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/prras_checker.sv -----
module prras_checker
    import prras_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // held response stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // requests back up only behind a stalled response
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stalled with response side free");

    // a fresh response follows a request taken through the execute stage
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
        else $error("response without matching request");

    // only a dispatch carries a slice length or a wait
    a_dispatch_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_DISPATCHED |-> rsp.run_length == '0 && rsp.waited == '0)
        else $error("slice fields set on a non-dispatch response");

endmodule

bind priority_round_robin_aging_scheduler prras_checker u_prras_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
